// File: hw/rtl/wvt_pkg.sv
package wvt_pkg;

	localparam int GRID_BITS   = 10;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int ELEV_W      = 16;
	localparam int PIX_W       = 16;
	localparam int COLOR_W     = 24;
	localparam int FRAC_BITS   = 16;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Product widths: weight times zero-extended grid index, weight times elevation.
	localparam int PC_W  = CFG_W + GRID_BITS + 1;
	localparam int PZ_W  = CFG_W + ELEV_W;
	localparam int MAG_W = (GRID_BITS + 1 > ELEV_W) ? GRID_BITS + 1 : ELEV_W;
	localparam int ACC_W = CFG_W + MAG_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_M_XX     = 3'd0,
		REG_M_XY     = 3'd1,
		REG_M_XZ     = 3'd2,
		REG_M_YX     = 3'd3,
		REG_M_YY     = 3'd4,
		REG_M_YZ     = 3'd5,
		REG_ORIGIN_X = 3'd6,
		REG_ORIGIN_Y = 3'd7
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] CFG_ONE  = 32'h0001_0000;
	localparam logic [CFG_W-1:0] CFG_ZERO = 32'h0000_0000;

	localparam logic [COLOR_W-1:0] COLOR_WHITE  = 24'hFFFFFF;
	localparam logic [COLOR_W-1:0] COLOR_CREAM  = 24'hFFFFCC;
	localparam logic [COLOR_W-1:0] COLOR_PALE   = 24'hFFFF66;
	localparam logic [COLOR_W-1:0] COLOR_YELLOW = 24'hFFFF00;
	localparam logic [COLOR_W-1:0] COLOR_AMBER  = 24'hFFCC00;
	localparam logic [COLOR_W-1:0] COLOR_ORANGE = 24'hFF9900;
	localparam logic [COLOR_W-1:0] COLOR_RUST   = 24'hFF6600;
	localparam logic [COLOR_W-1:0] COLOR_SCARLET = 24'hFF3300;
	localparam logic [COLOR_W-1:0] COLOR_RED    = 24'hFF0000;
	localparam logic [COLOR_W-1:0] COLOR_DARK   = 24'hCC0000;
	localparam logic [COLOR_W-1:0] COLOR_MAROON = 24'h990000;

	typedef struct packed {
		logic signed [CFG_W-1:0] m_xx;
		logic signed [CFG_W-1:0] m_xy;
		logic signed [CFG_W-1:0] m_xz;
		logic signed [CFG_W-1:0] m_yx;
		logic signed [CFG_W-1:0] m_yy;
		logic signed [CFG_W-1:0] m_yz;
		logic signed [CFG_W-1:0] origin_x;
		logic signed [CFG_W-1:0] origin_y;
	} proj_cfg_t;

	typedef struct packed {
		logic [GRID_BITS-1:0]     col;
		logic [GRID_BITS-1:0]     row;
		logic signed [ELEV_W-1:0] elev;
		logic [COLOR_W-1:0]       color;
	} vertex_t;

	// A negative height keeps the previous colour.
	function automatic logic [COLOR_W-1:0] height_color(input logic signed [ELEV_W-1:0] h,
		input logic [COLOR_W-1:0] prev);
		logic [COLOR_W-1:0] c;
		priority if (h < 0)   c = prev;
		else if (h >= 110)    c = COLOR_MAROON;
		else if (h >= 40)     c = COLOR_DARK;
		else if (h >= 30)     c = COLOR_RED;
		else if (h >= 22)     c = COLOR_SCARLET;
		else if (h >= 15)     c = COLOR_RUST;
		else if (h > 12)      c = COLOR_ORANGE;
		else if (h > 8)       c = COLOR_AMBER;
		else if (h > 5)       c = COLOR_YELLOW;
		else if (h > 2)       c = COLOR_PALE;
		else if (h > 0)       c = COLOR_CREAM;
		else                  c = COLOR_WHITE;
		return c;
	endfunction

endpackage

// File: hw/rtl/wvt_front.sv
module wvt_front import wvt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [GRID_BITS-1:0]     grid_col,
	input  logic [GRID_BITS-1:0]     grid_row,
	input  logic signed [ELEV_W-1:0] elevation,
	input  logic                     full,
	output logic                     push,
	output vertex_t                  push_data
);

	logic [COLOR_W-1:0] last_color_q;
	logic [COLOR_W-1:0] color;

	// The colour depends on the previous word, so it is settled here in order.
	assign color    = height_color(elevation, last_color_q);
	assign in_ready = !full;
	assign push     = in_valid && !full;

	assign push_data.col   = grid_col;
	assign push_data.row   = grid_row;
	assign push_data.elev  = elevation;
	assign push_data.color = color;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_color_q <= COLOR_WHITE;
		end else if (push) begin
			last_color_q <= color;
		end
	end

endmodule

// File: hw/rtl/wvt_queue.sv
module wvt_queue import wvt_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  vertex_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    not_empty,
	output vertex_t pop_data
);

	vertex_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_PTR_W:0]   count_q;

	assign full      = (count_q == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: hw/rtl/wvt_back.sv
module wvt_back import wvt_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  proj_cfg_t               cfg,
	input  logic                    q_valid,
	input  vertex_t                 q_data,
	output logic                    q_pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [PIX_W-1:0] screen_x,
	output logic signed [PIX_W-1:0] screen_y,
	output logic [COLOR_W-1:0]      pixel_color
);

	localparam int WHOLE_W = ACC_W - FRAC_BITS;

	// Truncate toward zero to whole pixels, then saturate to the pixel range.
	function automatic logic signed [PIX_W-1:0] to_pixel(input logic signed [ACC_W-1:0] acc);
		logic [WHOLE_W-1:0]     whole;
		logic                   bump;
		logic [WHOLE_W:0]       adj;
		logic [WHOLE_W-PIX_W+1:0] hi;
		logic signed [PIX_W-1:0] pix;
		whole = acc[ACC_W-1:FRAC_BITS];
		bump  = acc[ACC_W-1] && (|acc[FRAC_BITS-1:0]);
		adj   = {whole[WHOLE_W-1], whole} + {{WHOLE_W{1'b0}}, bump};
		hi    = adj[WHOLE_W:PIX_W-1];
		if ((&hi) || !(|hi)) begin
			pix = signed'(adj[PIX_W-1:0]);
		end else if (adj[WHOLE_W]) begin
			pix = signed'({1'b1, {(PIX_W-1){1'b0}}});
		end else begin
			pix = signed'({1'b0, {(PIX_W-1){1'b1}}});
		end
		return pix;
	endfunction

	logic signed [GRID_BITS:0] col_ext;
	logic signed [GRID_BITS:0] row_ext;

	logic                     valid_s1;
	logic signed [PC_W-1:0]   xc_s1, xr_s1, yc_s1, yr_s1;
	logic signed [PZ_W-1:0]   xz_s1, yz_s1;
	logic [COLOR_W-1:0]       color_s1;

	logic                     valid_s2;
	logic signed [ACC_W-1:0]  xa_s2, xb_s2, ya_s2, yb_s2;
	logic [COLOR_W-1:0]       color_s2;

	logic                     valid_s3;
	logic signed [ACC_W-1:0]  x_s3, y_s3;
	logic [COLOR_W-1:0]       color_s3;

	logic                     out_valid_q;
	logic signed [PIX_W-1:0]  screen_x_q, screen_y_q;
	logic [COLOR_W-1:0]       pixel_color_q;

	logic adv_out, adv_s3, adv_s2, adv_s1;

	// Each stage moves on when it is empty or the one after it moves on.
	assign adv_out = !out_valid_q || out_ready;
	assign adv_s3  = !valid_s3 || adv_out;
	assign adv_s2  = !valid_s2 || adv_s3;
	assign adv_s1  = !valid_s1 || adv_s2;
	assign q_pop   = q_valid && adv_s1;

	assign col_ext = signed'({1'b0, q_data.col});
	assign row_ext = signed'({1'b0, q_data.row});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= q_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
			if (adv_out) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			xc_s1    <= cfg.m_xx * col_ext;
			xr_s1    <= cfg.m_xy * row_ext;
			xz_s1    <= cfg.m_xz * q_data.elev;
			yc_s1    <= cfg.m_yx * col_ext;
			yr_s1    <= cfg.m_yy * row_ext;
			yz_s1    <= cfg.m_yz * q_data.elev;
			color_s1 <= q_data.color;
		end
		if (adv_s2 && valid_s1) begin
			xa_s2    <= ACC_W'(xc_s1) + ACC_W'(xr_s1);
			xb_s2    <= ACC_W'(cfg.origin_x) + ACC_W'(xz_s1);
			ya_s2    <= ACC_W'(yc_s1) + ACC_W'(yr_s1);
			yb_s2    <= ACC_W'(cfg.origin_y) + ACC_W'(yz_s1);
			color_s2 <= color_s1;
		end
		if (adv_s3 && valid_s2) begin
			x_s3     <= xa_s2 + xb_s2;
			y_s3     <= ya_s2 + yb_s2;
			color_s3 <= color_s2;
		end
		if (adv_out && valid_s3) begin
			screen_x_q    <= to_pixel(x_s3);
			screen_y_q    <= to_pixel(y_s3);
			pixel_color_q <= color_s3;
		end
	end

	assign out_valid   = out_valid_q;
	assign screen_x    = screen_x_q;
	assign screen_y    = screen_y_q;
	assign pixel_color = pixel_color_q;

endmodule

// File: hw/rtl/wireframe_vertex_transform.sv
// Wireframe vertex transform: one heightmap point in, one screen point out.
// The input channel (in_valid/in_ready) carries grid_col, grid_row and elevation;
// the output channel (out_valid/out_ready) carries screen_x, screen_y and
// pixel_color. The projection matrix and origins are Q15.16 registers written
// through cfg_we/cfg_index/cfg_data; the user must make these writes only while
// no word is in flight, as the block itself does not enforce it.
// A front stage picks the colour in arrival order and writes the word into a
// four-entry queue; the back end is a four-stage pipeline (products, partial
// sums, full sum, truncate and saturate into the output register).
// Throughput is one word per cycle while out_ready is high.
// When out_ready is low the pipeline fills and then the queue, so up to eight
// words are held before in_ready falls; nothing is lost or repeated.
// Reset clears the pipeline and queue, loads the identity projection with zero
// origins and sets the remembered colour to white.
module wireframe_vertex_transform import wvt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [GRID_BITS-1:0]     grid_col,
	input  logic [GRID_BITS-1:0]     grid_row,
	input  logic signed [ELEV_W-1:0] elevation,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [PIX_W-1:0]  screen_x,
	output logic signed [PIX_W-1:0]  screen_y,
	output logic [COLOR_W-1:0]       pixel_color
);

	proj_cfg_t cfg_q;
	logic      full;
	logic      push;
	vertex_t   push_data;
	logic      q_pop;
	logic      q_valid;
	vertex_t   q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.m_xx     <= CFG_ONE;
			cfg_q.m_xy     <= CFG_ZERO;
			cfg_q.m_xz     <= CFG_ZERO;
			cfg_q.m_yx     <= CFG_ZERO;
			cfg_q.m_yy     <= CFG_ONE;
			cfg_q.m_yz     <= CFG_ZERO;
			cfg_q.origin_x <= CFG_ZERO;
			cfg_q.origin_y <= CFG_ZERO;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_M_XX:     cfg_q.m_xx     <= cfg_data;
				REG_M_XY:     cfg_q.m_xy     <= cfg_data;
				REG_M_XZ:     cfg_q.m_xz     <= cfg_data;
				REG_M_YX:     cfg_q.m_yx     <= cfg_data;
				REG_M_YY:     cfg_q.m_yy     <= cfg_data;
				REG_M_YZ:     cfg_q.m_yz     <= cfg_data;
				REG_ORIGIN_X: cfg_q.origin_x <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data;
				default:      cfg_q          <= cfg_q;
			endcase
		end
	end

	wvt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.grid_col  (grid_col),
		.grid_row  (grid_row),
		.elevation (elevation),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	wvt_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	wvt_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.q_valid     (q_valid),
		.q_data      (q_data),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.screen_x    (screen_x),
		.screen_y    (screen_y),
		.pixel_color (pixel_color)
	);

endmodule
